// ===== hdl/cbs_pkg.sv =====
// types and constants shared by the codebook background subtractor
// no dependencies
`default_nettype none

package cbs_pkg;

    localparam int BOUND_W   = 10;
    localparam int PIX_W     = 17;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        logic [7:0]       pixel_value;
        logic [PIX_W-1:0] pixel_index;
        logic             frame_end;
    } in_t;

    typedef struct packed {
        logic foreground;
        logic learning;
    } out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_MARGIN      = 3'd0,
        CFG_BLEND_WEIGHT      = 3'd1,
        CFG_LEARN_FRAMES      = 3'd2,
        CFG_MAIN_DELETE_IDLE  = 3'd3,
        CFG_CACHE_DELETE_IDLE = 3'd4,
        CFG_PROMOTE_HITS      = 3'd5
    } cfg_idx_t;

    typedef enum logic [16:0] {
        ST_CLEAR    = 17'h00001,
        ST_IDLE     = 17'h00002,
        ST_CNT      = 17'h00004,
        ST_LD_REQ   = 17'h00008,
        ST_LD_CAP   = 17'h00010,
        ST_SCAN     = 17'h00020,
        ST_MUL1     = 17'h00040,
        ST_MUL2     = 17'h00080,
        ST_ADD      = 17'h00100,
        ST_DPREP    = 17'h00200,
        ST_DIV      = 17'h00400,
        ST_BLEND    = 17'h00800,
        ST_FIN      = 17'h01000,
        ST_NEW      = 17'h02000,
        ST_WB_MAIN  = 17'h04000,
        ST_WB_CACHE = 17'h08000,
        ST_DONE     = 17'h10000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/cbs_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module cbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/codebook_background_subtractor.sv =====
// codebook background subtractor top level: sequencer, shared datapath, list rams
// depends on cbs_pkg and cbs_ram
`default_nettype none

// One grayscale pixel per transaction. Each pixel position has a main and a
// cache list of up to MAX_CODEWORDS codewords held in rams, with a fill count
// per position. After reset a clearing pass over all FRAME_PIXELS positions
// zeroes the fill counts; no pixel is taken meanwhile. An accepted pixel has
// its fill counts read, then both lists loaded from ram up to the longer of
// the two, one entry of each per request and capture state; then each list
// handled (the main list, and the cache list too when a detection pixel misses
// the main list) is scanned and written back. For a matched codeword the two
// bounds are updated through one shared multiplier, by blending or, when
// learning, by a bit-serial divider. An out-of-range pixel index goes straight
// to the result. in_ready is high only while the sequencer is idle; the result
// sits in an output register, and the last cycle of a pixel waits while the
// previous result has not been taken.

module codebook_background_subtractor #(
    parameter int MAX_CODEWORDS = 8,
    parameter int FRAME_PIXELS  = 131072,
    parameter int COUNT_WIDTH   = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire cbs_pkg::in_t                     in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output cbs_pkg::out_t                         out_data,
    input  wire logic                             cfg_write,
    input  wire logic [cbs_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [cbs_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int CW    = COUNT_WIDTH;
    localparam int BW    = cbs_pkg::BOUND_W;
    localparam int K_W   = $clog2(MAX_CODEWORDS + 1);
    localparam int LI_W  = $clog2(2 * MAX_CODEWORDS);
    localparam int PA_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int SLOTS = FRAME_PIXELS * MAX_CODEWORDS;
    localparam int EA_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENT_W = 2 * BW + 2 * CW;
    localparam int NUM_W = CW + 12;
    localparam int DC_W  = $clog2(NUM_W + 1);
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    cbs_pkg::state_t state_reg, state_next;

    // configuration
    logic [7:0]  margin_reg, beta_reg;
    logic [15:0] learn_frames_reg, mdel_reg, cdel_reg, promote_reg;
    logic [15:0] frame_cnt_reg;

    // control
    logic [PA_W-1:0] clr_reg;
    logic [7:0]      px_reg;
    logic [PA_W-1:0] pix_reg;
    logic            fend_reg, learn_reg, fg_reg;
    logic [K_W-1:0]  mcnt_reg, ccnt_reg, mtot_reg, k_reg, r_reg, w_reg;
    logic            sel_reg, found_reg, bsel_reg;
    logic            out_valid_reg;
    cbs_pkg::out_t   out_data_reg;

    // datapath
    logic signed [CW+10:0] prod_reg, prod2_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] dv_reg;
    logic [CW:0]      rem_reg;
    logic             neg_reg;
    logic [DC_W-1:0]  dcnt_reg;
    logic signed [BW-1:0] res_low_reg, res_high_reg;

    // working copy of both lists: main in the lower half, cache in the upper
    logic signed [BW-1:0] loc_low  [2*MAX_CODEWORDS];
    logic signed [BW-1:0] loc_high [2*MAX_CODEWORDS];
    logic [CW-1:0]        loc_hits [2*MAX_CODEWORDS];
    logic [CW-1:0]        loc_idle [2*MAX_CODEWORDS];

    // ram ports
    logic [K_W-1:0]   main_cnt_rd, cache_cnt_rd;
    logic             mcnt_we, ccnt_we;
    logic [PA_W-1:0]  cnt_waddr, cnt_raddr;
    logic [K_W-1:0]   mcnt_wdata, ccnt_wdata;
    logic [ENT_W-1:0] main_ent_rd, cache_ent_rd, ent_wdata;
    logic             ment_we, cent_we;
    logic [EA_W-1:0]  ment_waddr, cent_waddr, ent_raddr, base;

    // combinational
    logic             in_range, is_wb, match, blend_mode, keep_main, drop_c, promote_c;
    logic [K_W-1:0]   n_cur, nload, sel_pos;
    logic [LI_W-1:0]  rd_idx, nw_idx;
    logic signed [BW-1:0] p10, pl, ph, plh, c_low, c_high, nw_low, nw_high;
    logic signed [BW-1:0] bound_val, dv_val, bl_val;
    logic [CW-1:0]    c_hits, c_idle, hits_inc, idle_inc;
    logic [8:0]       nb;
    logic signed [CW:0]    mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [CW+10:0] mul_p;
    logic signed [NUM_W-1:0] sum;
    logic [NUM_W-1:0] mag;
    logic [CW:0]      dsr;
    logic [CW+1:0]    trial, trial_sub;
    logic             ge, bound_done, out_go, wb_main_end, wb_cache_end;

    assign in_ready  = (state_reg == cbs_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_range = 64'(in_data.pixel_index) < 64'(FRAME_PIXELS);
    assign base     = EA_W'(pix_reg) * EA_W'(MAX_CODEWORDS);
    assign is_wb    = (state_reg == cbs_pkg::ST_WB_MAIN) || (state_reg == cbs_pkg::ST_WB_CACHE);
    assign sel_pos  = is_wb ? r_reg : k_reg;
    assign rd_idx   = sel_reg ? LI_W'(MAX_CODEWORDS) + LI_W'(sel_pos) : LI_W'(sel_pos);
    assign n_cur    = sel_reg ? ccnt_reg : mcnt_reg;
    assign nw_idx   = sel_reg ? LI_W'(MAX_CODEWORDS) + LI_W'(n_cur) : LI_W'(n_cur);
    assign nload    = (mcnt_reg > ccnt_reg) ? mcnt_reg : ccnt_reg;

    assign c_low  = loc_low[rd_idx];
    assign c_high = loc_high[rd_idx];
    assign c_hits = loc_hits[rd_idx];
    assign c_idle = loc_idle[rd_idx];

    assign hits_inc = (c_hits == COUNT_MAX) ? c_hits : c_hits + 1'b1;
    assign idle_inc = (c_idle == COUNT_MAX) ? c_idle : c_idle + 1'b1;

    assign p10     = signed'({2'b00, px_reg});
    assign pl      = p10 - signed'({2'b00, margin_reg});
    assign ph      = p10 + signed'({2'b00, margin_reg});
    assign plh     = bsel_reg ? ph : pl;
    assign nw_low  = (pl < 0) ? BW'(0) : pl;
    assign nw_high = (ph > 255) ? BW'(255) : ph;
    assign match   = (c_low <= p10) && (p10 <= c_high);
    assign blend_mode = !learn_reg || sel_reg;

    // shared multiplier
    assign nb = 9'd256 - {1'b0, beta_reg};
    always_comb
    begin
        if (state_reg == cbs_pkg::ST_MUL2)
        begin
            mul_a = signed'((CW+1)'(nb));
            mul_b = plh;
        end
        else
        begin
            mul_a = blend_mode ? signed'((CW+1)'(beta_reg)) : signed'({1'b0, c_hits});
            mul_b = bsel_reg ? c_high : c_low;
        end
    end
    assign mul_p = mul_a * mul_b;

    assign sum = blend_mode ? NUM_W'(prod_reg) + NUM_W'(prod2_reg)
                            : NUM_W'(prod_reg) + NUM_W'(plh);
    assign mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign bl_val = BW'(num_reg[NUM_W-1] ? -(mag >> 8) : (mag >> 8));

    // restoring divider step, divisor is hits + 1
    assign dsr       = {1'b0, c_hits} + 1'b1;
    assign trial     = {rem_reg, dv_reg[NUM_W-1]};
    assign trial_sub = trial - (CW+2)'(dsr);
    assign ge        = trial >= (CW+2)'(dsr);
    assign dv_val    = BW'(neg_reg ? -dv_reg : dv_reg);

    assign bound_done = ((state_reg == cbs_pkg::ST_DIV) && (dcnt_reg == '0))
                        || (state_reg == cbs_pkg::ST_BLEND);
    assign bound_val  = (state_reg == cbs_pkg::ST_BLEND) ? bl_val : dv_val;

    assign keep_main = learn_reg || (32'(c_idle) < 32'(mdel_reg));
    assign drop_c    = 32'(c_idle) >= 32'(cdel_reg);
    assign promote_c = 32'(c_hits) > 32'(promote_reg);

    assign wb_main_end  = (state_reg == cbs_pkg::ST_WB_MAIN) && (r_reg == mcnt_reg);
    assign wb_cache_end = (state_reg == cbs_pkg::ST_WB_CACHE) && (r_reg == ccnt_reg);
    assign out_go = (state_reg == cbs_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // ram port control
    assign cnt_raddr = PA_W'(in_data.pixel_index);
    assign cnt_waddr = (state_reg == cbs_pkg::ST_CLEAR) ? clr_reg : pix_reg;
    assign mcnt_we   = (state_reg == cbs_pkg::ST_CLEAR) || wb_main_end || wb_cache_end;
    assign ccnt_we   = (state_reg == cbs_pkg::ST_CLEAR) || wb_cache_end;
    assign mcnt_wdata = (state_reg == cbs_pkg::ST_CLEAR) ? '0 : (wb_main_end ? w_reg : mtot_reg);
    assign ccnt_wdata = (state_reg == cbs_pkg::ST_CLEAR) ? '0 : w_reg;

    assign ent_raddr  = base + EA_W'(k_reg);
    assign ent_wdata  = {c_low, c_high, c_hits, c_idle};
    assign ment_we    = ((state_reg == cbs_pkg::ST_WB_MAIN) && !wb_main_end && keep_main)
                        || ((state_reg == cbs_pkg::ST_WB_CACHE) && !wb_cache_end && !drop_c
                            && promote_c && (mtot_reg < K_W'(MAX_CODEWORDS)));
    assign ment_waddr = base + EA_W'((state_reg == cbs_pkg::ST_WB_MAIN) ? w_reg : mtot_reg);
    assign cent_we    = (state_reg == cbs_pkg::ST_WB_CACHE) && !wb_cache_end && !drop_c
                        && !promote_c;
    assign cent_waddr = base + EA_W'(w_reg);

    cbs_ram #(.WIDTH(K_W), .DEPTH(FRAME_PIXELS)) u_main_cnt (
        .clk(clk), .we(mcnt_we), .waddr(cnt_waddr), .wdata(mcnt_wdata),
        .raddr(cnt_raddr), .rdata(main_cnt_rd)
    );

    cbs_ram #(.WIDTH(K_W), .DEPTH(FRAME_PIXELS)) u_cache_cnt (
        .clk(clk), .we(ccnt_we), .waddr(cnt_waddr), .wdata(ccnt_wdata),
        .raddr(cnt_raddr), .rdata(cache_cnt_rd)
    );

    cbs_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_main_ent (
        .clk(clk), .we(ment_we), .waddr(ment_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(main_ent_rd)
    );

    cbs_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_cache_ent (
        .clk(clk), .we(cent_we), .waddr(cent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(cache_ent_rd)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbs_pkg::ST_CLEAR:
            begin
                if (clr_reg == PA_W'(FRAME_PIXELS - 1))
                begin
                    state_next = cbs_pkg::ST_IDLE;
                end
            end
            cbs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_range ? cbs_pkg::ST_CNT : cbs_pkg::ST_DONE;
                end
            end
            cbs_pkg::ST_CNT:    state_next = cbs_pkg::ST_LD_REQ;
            cbs_pkg::ST_LD_REQ: state_next = (k_reg == nload) ? cbs_pkg::ST_SCAN
                                                               : cbs_pkg::ST_LD_CAP;
            cbs_pkg::ST_LD_CAP: state_next = cbs_pkg::ST_LD_REQ;
            cbs_pkg::ST_SCAN:
            begin
                if (k_reg == n_cur)
                begin
                    state_next = cbs_pkg::ST_NEW;
                end
                else if (match && !found_reg)
                begin
                    state_next = cbs_pkg::ST_MUL1;
                end
            end
            cbs_pkg::ST_MUL1:  state_next = blend_mode ? cbs_pkg::ST_MUL2 : cbs_pkg::ST_ADD;
            cbs_pkg::ST_MUL2:  state_next = cbs_pkg::ST_ADD;
            cbs_pkg::ST_ADD:   state_next = blend_mode ? cbs_pkg::ST_BLEND : cbs_pkg::ST_DPREP;
            cbs_pkg::ST_DPREP: state_next = cbs_pkg::ST_DIV;
            cbs_pkg::ST_DIV,
            cbs_pkg::ST_BLEND:
            begin
                if (bound_done)
                begin
                    state_next = bsel_reg ? cbs_pkg::ST_FIN : cbs_pkg::ST_MUL1;
                end
            end
            cbs_pkg::ST_FIN:   state_next = cbs_pkg::ST_SCAN;
            cbs_pkg::ST_NEW:   state_next = sel_reg ? cbs_pkg::ST_WB_CACHE
                                                    : cbs_pkg::ST_WB_MAIN;
            cbs_pkg::ST_WB_MAIN:
            begin
                if (wb_main_end)
                begin
                    state_next = (learn_reg || found_reg) ? cbs_pkg::ST_DONE
                                                          : cbs_pkg::ST_SCAN;
                end
            end
            cbs_pkg::ST_WB_CACHE:
            begin
                if (wb_cache_end)
                begin
                    state_next = cbs_pkg::ST_DONE;
                end
            end
            cbs_pkg::ST_DONE:
            begin
                if (out_go)
                begin
                    state_next = cbs_pkg::ST_IDLE;
                end
            end
            default: state_next = cbs_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cbs_pkg::ST_CLEAR;
            clr_reg          <= '0;
            margin_reg       <= 8'd10;
            beta_reg         <= 8'd179;
            learn_frames_reg <= 16'd10;
            mdel_reg         <= 16'd200;
            cdel_reg         <= 16'd20;
            promote_reg      <= 16'd20;
            frame_cnt_reg    <= '0;
            fend_reg         <= 1'b0;
            learn_reg        <= 1'b0;
            fg_reg           <= 1'b0;
            mcnt_reg         <= '0;
            ccnt_reg         <= '0;
            mtot_reg         <= '0;
            k_reg            <= '0;
            r_reg            <= '0;
            w_reg            <= '0;
            sel_reg          <= 1'b0;
            found_reg        <= 1'b0;
            bsel_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_addr)
                    cbs_pkg::CFG_MATCH_MARGIN:      margin_reg       <= cfg_wdata[7:0];
                    cbs_pkg::CFG_BLEND_WEIGHT:      beta_reg         <= cfg_wdata[7:0];
                    cbs_pkg::CFG_LEARN_FRAMES:      learn_frames_reg <= cfg_wdata;
                    cbs_pkg::CFG_MAIN_DELETE_IDLE:  mdel_reg         <= cfg_wdata;
                    cbs_pkg::CFG_CACHE_DELETE_IDLE: cdel_reg         <= cfg_wdata;
                    cbs_pkg::CFG_PROMOTE_HITS:      promote_reg      <= cfg_wdata;
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && !out_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                cbs_pkg::ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                cbs_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        fend_reg  <= in_data.frame_end;
                        learn_reg <= frame_cnt_reg <= learn_frames_reg;
                        fg_reg    <= 1'b0;
                    end
                end
                cbs_pkg::ST_CNT:
                begin
                    mcnt_reg  <= main_cnt_rd;
                    ccnt_reg  <= cache_cnt_rd;
                    k_reg     <= '0;
                    sel_reg   <= 1'b0;
                    found_reg <= 1'b0;
                end
                cbs_pkg::ST_LD_REQ:
                begin
                    if (k_reg == nload)
                    begin
                        k_reg <= '0;
                    end
                end
                cbs_pkg::ST_LD_CAP:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                cbs_pkg::ST_SCAN:
                begin
                    if (k_reg != n_cur)
                    begin
                        if (match && !found_reg)
                        begin
                            bsel_reg <= 1'b0;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                cbs_pkg::ST_DIV,
                cbs_pkg::ST_BLEND:
                begin
                    if (bound_done)
                    begin
                        bsel_reg <= 1'b1;
                    end
                end
                cbs_pkg::ST_FIN:
                begin
                    found_reg <= 1'b1;
                    k_reg     <= k_reg + 1'b1;
                end
                cbs_pkg::ST_NEW:
                begin
                    if (!found_reg && (n_cur < K_W'(MAX_CODEWORDS)) && (sel_reg || learn_reg))
                    begin
                        if (sel_reg)
                        begin
                            ccnt_reg <= ccnt_reg + 1'b1;
                        end
                        else
                        begin
                            mcnt_reg <= mcnt_reg + 1'b1;
                        end
                    end
                    r_reg <= '0;
                    w_reg <= '0;
                end
                cbs_pkg::ST_WB_MAIN:
                begin
                    if (wb_main_end)
                    begin
                        mtot_reg <= w_reg;
                        fg_reg   <= !learn_reg && !found_reg;
                        if (!learn_reg && !found_reg)
                        begin
                            sel_reg <= 1'b1;
                            k_reg   <= '0;
                        end
                    end
                    else
                    begin
                        if (keep_main)
                        begin
                            w_reg <= w_reg + 1'b1;
                        end
                        r_reg <= r_reg + 1'b1;
                    end
                end
                cbs_pkg::ST_WB_CACHE:
                begin
                    if (!wb_cache_end)
                    begin
                        if (!drop_c)
                        begin
                            if (promote_c)
                            begin
                                if (mtot_reg < K_W'(MAX_CODEWORDS))
                                begin
                                    mtot_reg <= mtot_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                w_reg <= w_reg + 1'b1;
                            end
                        end
                        r_reg <= r_reg + 1'b1;
                    end
                end
                cbs_pkg::ST_DONE:
                begin
                    if (out_go)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_data_reg.foreground <= fg_reg;
                        out_data_reg.learning   <= learn_reg;
                        if (fend_reg && learn_reg && (frame_cnt_reg != 16'hFFFF))
                        begin
                            frame_cnt_reg <= frame_cnt_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cbs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    px_reg  <= in_data.pixel_value;
                    pix_reg <= PA_W'(in_data.pixel_index);
                end
            end
            cbs_pkg::ST_LD_CAP:
            begin
                {loc_low[LI_W'(k_reg)], loc_high[LI_W'(k_reg)],
                 loc_hits[LI_W'(k_reg)], loc_idle[LI_W'(k_reg)]} <= main_ent_rd;
                {loc_low[LI_W'(MAX_CODEWORDS) + LI_W'(k_reg)],
                 loc_high[LI_W'(MAX_CODEWORDS) + LI_W'(k_reg)],
                 loc_hits[LI_W'(MAX_CODEWORDS) + LI_W'(k_reg)],
                 loc_idle[LI_W'(MAX_CODEWORDS) + LI_W'(k_reg)]} <= cache_ent_rd;
            end
            cbs_pkg::ST_SCAN:
            begin
                if ((k_reg != n_cur) && !(match && !found_reg))
                begin
                    loc_idle[rd_idx] <= idle_inc;
                end
            end
            cbs_pkg::ST_MUL1:
            begin
                prod_reg <= mul_p;
            end
            cbs_pkg::ST_MUL2:
            begin
                prod2_reg <= mul_p;
            end
            cbs_pkg::ST_ADD:
            begin
                num_reg <= sum;
            end
            cbs_pkg::ST_DPREP:
            begin
                dv_reg   <= mag;
                neg_reg  <= num_reg[NUM_W-1];
                rem_reg  <= '0;
                dcnt_reg <= DC_W'(NUM_W);
            end
            cbs_pkg::ST_DIV,
            cbs_pkg::ST_BLEND:
            begin
                if (bound_done)
                begin
                    if (bsel_reg)
                    begin
                        res_high_reg <= bound_val;
                    end
                    else
                    begin
                        res_low_reg <= bound_val;
                    end
                end
                else
                begin
                    // one quotient bit per cycle
                    rem_reg  <= ge ? trial_sub[CW:0] : trial[CW:0];
                    dv_reg   <= {dv_reg[NUM_W-2:0], ge};
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
            end
            cbs_pkg::ST_FIN:
            begin
                loc_low[rd_idx]  <= res_low_reg;
                loc_high[rd_idx] <= res_high_reg;
                loc_hits[rd_idx] <= hits_inc;
                loc_idle[rd_idx] <= '0;
            end
            cbs_pkg::ST_NEW:
            begin
                if (!found_reg && (n_cur < K_W'(MAX_CODEWORDS)) && (sel_reg || learn_reg))
                begin
                    loc_low[nw_idx]  <= nw_low;
                    loc_high[nw_idx] <= nw_high;
                    loc_hits[nw_idx] <= CW'(1);
                    loc_idle[nw_idx] <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/cbs_checker.sv =====
// result checker for the codebook background subtractor: tracks config writes,
// predicts each pixel result from its own copy of the codebooks and compares
// depends on cbs_pkg
`timescale 1ns / 1ps

module cbs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  cbs_pkg::in_t                  in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  cbs_pkg::out_t                 out_data,
    input  logic                          cfg_write,
    input  logic [cbs_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [cbs_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            errors,
    output int                            pending
);

    localparam int WORDS     = 8;
    localparam int COUNT_TOP = 65535;
    localparam int PIXELS    = 131072;

    typedef struct {
        int          lo;
        int          hi;
        int unsigned hits;
        int unsigned idle;
    } codeword_t;

    typedef struct {
        codeword_t w[WORDS];
        int        n;
    } codebook_t;

    codebook_t     main_books[int];
    codebook_t     cache_books[int];
    int unsigned   frames;
    int unsigned   margin, beta, learn_limit, main_thr, cache_thr, promote_thr;
    cbs_pkg::out_t result_q[$];

    function automatic int unsigned bump(int unsigned x);
        return (x >= COUNT_TOP) ? COUNT_TOP : x + 1;
    endfunction

    function automatic void add_word(inout codebook_t b, input int lo, input int hi,
                                     input int unsigned hits, input int unsigned idle);
        if (b.n < WORDS)
        begin
            b.w[b.n].lo   = lo;
            b.w[b.n].hi   = hi;
            b.w[b.n].hits = hits;
            b.w[b.n].idle = idle;
            b.n++;
        end
    endfunction

    function automatic void seed_word(inout codebook_t b, input int p);
        int lo;
        int hi;
        lo = p - int'(margin);
        hi = p + int'(margin);
        if (lo < 0) lo = 0;
        if (hi > 255) hi = 255;
        add_word(b, lo, hi, 1, 0);
    endfunction

    function automatic void drop_idle(inout codebook_t b, input int unsigned thr);
        int w;
        w = 0;
        for (int r = 0; r < b.n; r++)
        begin
            if (b.w[r].idle < thr)
            begin
                b.w[w] = b.w[r];
                w++;
            end
        end
        b.n = w;
    endfunction

    function automatic bit blend_match(inout codebook_t b, input int p);
        bit    hit;
        longint wo, wn, pl, ph;
        hit = 0;
        wo  = longint'(beta);
        wn  = 256 - longint'(beta);
        pl  = longint'(p) - longint'(margin);
        ph  = longint'(p) + longint'(margin);
        for (int k = 0; k < b.n; k++)
        begin
            if (!hit && b.w[k].lo <= p && p <= b.w[k].hi)
            begin
                b.w[k].lo   = int'((wn * pl + wo * longint'(b.w[k].lo)) / 256);
                b.w[k].hi   = int'((wn * ph + wo * longint'(b.w[k].hi)) / 256);
                b.w[k].idle = 0;
                b.w[k].hits = bump(b.w[k].hits);
                hit = 1;
            end
            else
                b.w[k].idle = bump(b.w[k].idle);
        end
        return hit;
    endfunction

    function automatic cbs_pkg::out_t classify_pixel(cbs_pkg::in_t d);
        cbs_pkg::out_t r;
        codebook_t     mb, cb, kept;
        int            p, idx;
        bit            learn, hit;
        longint        f, pl, ph;
        p     = int'(d.pixel_value);
        idx   = int'(d.pixel_index);
        learn = (frames <= learn_limit);
        r.foreground = 1'b0;
        r.learning   = learn;
        if (idx < PIXELS)
        begin
            mb.n = 0;
            cb.n = 0;
            if (main_books.exists(idx)) mb = main_books[idx];
            if (cache_books.exists(idx)) cb = cache_books[idx];
            if (learn)
            begin
                hit = 0;
                pl  = longint'(p) - longint'(margin);
                ph  = longint'(p) + longint'(margin);
                for (int k = 0; k < mb.n; k++)
                begin
                    if (!hit && mb.w[k].lo <= p && p <= mb.w[k].hi)
                    begin
                        f = longint'(mb.w[k].hits);
                        mb.w[k].lo   = int'((pl + f * longint'(mb.w[k].lo)) / (f + 1));
                        mb.w[k].hi   = int'((ph + f * longint'(mb.w[k].hi)) / (f + 1));
                        mb.w[k].idle = 0;
                        mb.w[k].hits = bump(mb.w[k].hits);
                        hit = 1;
                    end
                    else
                        mb.w[k].idle = bump(mb.w[k].idle);
                end
                if (!hit) seed_word(mb, p);
            end
            else
            begin
                hit = blend_match(mb, p);
                drop_idle(mb, main_thr);
                r.foreground = !hit;
                if (!hit)
                begin
                    if (!blend_match(cb, p)) seed_word(cb, p);
                    drop_idle(cb, cache_thr);
                    // frequent cache words leave the cache; main takes them while it has room
                    kept.n = 0;
                    for (int k = 0; k < cb.n; k++)
                    begin
                        if (cb.w[k].hits > promote_thr)
                            add_word(mb, cb.w[k].lo, cb.w[k].hi, cb.w[k].hits, cb.w[k].idle);
                        else
                            add_word(kept, cb.w[k].lo, cb.w[k].hi, cb.w[k].hits, cb.w[k].idle);
                    end
                    cb = kept;
                end
            end
            main_books[idx]  = mb;
            cache_books[idx] = cb;
        end
        if (d.frame_end && learn && frames < 16'hFFFF) frames++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_books.delete();
            cache_books.delete();
            result_q.delete();
            frames      = 0;
            margin      = 10;
            beta        = 179;
            learn_limit = 10;
            main_thr    = 200;
            cache_thr   = 20;
            promote_thr = 20;
            pending     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cbs_pkg::cfg_idx_t'(cfg_addr))
                    cbs_pkg::CFG_MATCH_MARGIN:      margin      = cfg_wdata[7:0];
                    cbs_pkg::CFG_BLEND_WEIGHT:      beta        = cfg_wdata[7:0];
                    cbs_pkg::CFG_LEARN_FRAMES:      learn_limit = cfg_wdata;
                    cbs_pkg::CFG_MAIN_DELETE_IDLE:  main_thr    = cfg_wdata;
                    cbs_pkg::CFG_CACHE_DELETE_IDLE: cache_thr   = cfg_wdata;
                    cbs_pkg::CFG_PROMOTE_HITS:      promote_thr = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                result_q = {result_q, classify_pixel(in_data)};
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result transaction: fg=%0b learn=%0b",
                                 out_data.foreground, out_data.learning);
                    errors++;
                end
                else
                begin
                    cbs_pkg::out_t exp_r;
                    exp_r = result_q.pop_front();
                    if (exp_r.foreground !== out_data.foreground ||
                        exp_r.learning !== out_data.learning)
                    begin
                        if (errors < 10)
                            $display("mismatch at %0t: expected fg=%0b learn=%0b, got fg=%0b learn=%0b",
                                     $time, exp_r.foreground, exp_r.learning,
                                     out_data.foreground, out_data.learning);
                        errors++;
                    end
                end
            end
            pending = result_q.size();
        end
    end

endmodule

// ===== sim/tb_codebook_background_subtractor.sv =====
// top of the codebook background subtractor testbench: clock, reset, pixel and
// config stimulus, output stalls and verdict; depends on cbs_pkg, cbs_checker and codebook_background_subtractor
`timescale 1ns / 1ps

module tb_codebook_background_subtractor;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    cbs_pkg::in_t                  in_data   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    cbs_pkg::out_t                 out_data;
    logic                          cfg_write = 1'b0;
    logic [cbs_pkg::CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [cbs_pkg::CFG_W-1:0]     cfg_wdata = '0;
    int                            errors;
    int                            pending;
    int                            sent_cnt  = 0;
    int                            burst_left = 0;
    bit                            hold_valid = 1'b0;
    int                            pool_idx[6];
    int                            pool_bg[6];

    always #10 clk = ~clk;

    codebook_background_subtractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    cbs_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // called at a rising edge; returns at the transaction edge, or after a pause with in_valid low when a burst ends
    task automatic send_pixel(input int val, input int idx, input bit fe);
        in_valid              <= 1'b1;
        in_data.pixel_value   <= val[7:0];
        in_data.pixel_index   <= idx[cbs_pkg::PIX_W-1:0];
        in_data.frame_end     <= fe;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        sent_cnt++;
        if (burst_left > 0)
        begin
            burst_left--;
            hold_valid = 1'b1;
        end
        else
        begin
            in_valid <= 1'b0;
            hold_valid = 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input cbs_pkg::cfg_idx_t idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[cbs_pkg::CFG_W-1:0];
    endtask

    task automatic quiesce();
        if (hold_valid)
            in_valid <= 1'b0;
        hold_valid = 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(input int m, input int b, input int lf,
                             input int md, input int cd, input int ph);
        quiesce();
        write_reg(cbs_pkg::CFG_MATCH_MARGIN, m);
        write_reg(cbs_pkg::CFG_BLEND_WEIGHT, b);
        write_reg(cbs_pkg::CFG_LEARN_FRAMES, lf);
        write_reg(cbs_pkg::CFG_MAIN_DELETE_IDLE, md);
        write_reg(cbs_pkg::CFG_CACHE_DELETE_IDLE, cd);
        write_reg(cbs_pkg::CFG_PROMOTE_HITS, ph);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // mostly stable per-pixel scenes with noise, plus outliers and scene changes
    task automatic random_pixels(input int count);
        int k, v, idx;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0: idx = $urandom_range(0, 131071);
                1: idx = 131071;
                default: idx = pool_idx[k];
            endcase
            if ($urandom_range(0, 29) == 0) pool_bg[k] = $urandom_range(0, 255);
            if ($urandom_range(0, 4) == 0 || idx != pool_idx[k])
                v = $urandom_range(0, 255);
            else
            begin
                v = pool_bg[k] + $urandom_range(0, 8) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            send_pixel(v, idx, $urandom_range(0, 5) == 0);
        end
    endtask

    // receiver stalls: the pattern is picked anew periodically, one long hold-off
    initial
    begin
        int mode;
        int cyc;
        bit held;
        held = 0;
        cyc  = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent_cnt >= 60)
            begin
                held = 1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            cyc++;
            case (mode)
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= 1'b1;
            endcase
        end
    end

    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        pool_idx = '{0, 1, 2, 3, 17'h15555, 17'h0AAAA};
        foreach (pool_bg[i]) pool_bg[i] = $urandom_range(0, 255);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, both bounds of index, bit toggles, frame ends
        send_pixel(0, 0, 0);
        send_pixel(255, 0, 0);
        send_pixel(0, 131071, 0);
        send_pixel(255, 131071, 1);
        send_pixel(128, 0, 0);
        send_pixel(5, 1, 0);
        send_pixel(250, 1, 0);
        send_pixel(128, 17'h15555, 0);
        send_pixel(127, 17'h0AAAA, 1);
        send_pixel(129, 0, 0);
        send_pixel(6, 1, 0);
        send_pixel(255, 131071, 1);
        send_pixel(0, 131071, 0);
        send_pixel(255, 17'h15555, 0);

        // learn a few more frames, then detect with short idle limits
        configure(10, 179, 6, 50, 8, 3);
        random_pixels(150);
        // no learning, zero margin and blend weight, idle limits of one and a zero promote threshold
        configure(0, 0, 0, 1, 1, 0);
        random_pixels(110);
        // widest margin, largest old-bound weight, largest thresholds
        configure(255, 255, 0, 65535, 65535, 65535);
        random_pixels(110);
        // back into learning with the longest learning window
        configure(40, 128, 65535, 300, 30, 5);
        random_pixels(110);

        quiesce();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== codebook_background_subtractor.f =====
hdl/cbs_pkg.sv
hdl/cbs_ram.sv
hdl/codebook_background_subtractor.sv
sim/cbs_checker.sv
sim/tb_codebook_background_subtractor.sv
